// ===== src/tpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types, constants and emit-order tables for the triangle plane clipper
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned NumSplit  = 2;
  localparam int unsigned NumCoord  = 3;
  localparam int unsigned NumLane   = NumSplit * NumCoord;
  localparam int unsigned QuoW      = 33;
  localparam int unsigned BitsPerDv = 3;
  localparam int unsigned DivSteps  = QuoW / BitsPerDv;
  localparam int unsigned IdxW      = 4;
  localparam logic [IdxW-1:0] LastIdxSmall = IdxW'(3 - 1);
  localparam logic [IdxW-1:0] LastIdxTwo   = IdxW'(9 - 1);

  typedef logic [NumCoord-1:0][CoordW-1:0] vert_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_TWO,
    MODE_ALL
  } mode_e;

  typedef enum logic [2:0] {
    SRC_K0,
    SRC_K1,
    SRC_K2,
    SRC_S0,
    SRC_S1
  } src_e;

  function automatic src_e emit_src(mode_e mode, logic [IdxW-1:0] idx);
    src_e s;
    s = SRC_K2;
    case (mode)
      MODE_ALL: begin
        case (idx)
          4'd0:    s = SRC_K0;
          4'd1:    s = SRC_K1;
          default: s = SRC_K2;
        endcase
      end
      MODE_ONE: begin
        case (idx)
          4'd0:    s = SRC_S0;
          4'd1:    s = SRC_S1;
          default: s = SRC_K2;
        endcase
      end
      MODE_TWO: begin
        case (idx)
          4'd0:    s = SRC_K0;
          4'd1:    s = SRC_S0;
          4'd2:    s = SRC_K2;
          4'd3:    s = SRC_K2;
          4'd4:    s = SRC_S0;
          4'd5:    s = SRC_S1;
          4'd6:    s = SRC_K2;
          4'd7:    s = SRC_S1;
          default: s = SRC_K1;
        endcase
      end
      default: s = SRC_K2;
    endcase
    return s;
  endfunction

  function automatic logic emit_last(mode_e mode, logic [IdxW-1:0] idx);
    logic l;
    case (mode)
      MODE_TWO: l = (idx == LastIdxTwo);
      default:  l = (idx == LastIdxSmall);
    endcase
    return l;
  endfunction

  function automatic logic [1:0] nxt3(logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/tpc_split_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_split_lane
// one coordinate of one split point: p + round(d*a/(a-b)), radix-8 divider
// ----------------------------------------------------------------------------
module tpc_split_lane
  import tpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] p_i,
  input  logic signed [CoordW-1:0] q_i,
  input  logic signed [CoordW-1:0] a_i,
  input  logic signed [CoordW-1:0] b_i,
  output logic                     done_o,
  output logic        [CoordW-1:0] res_o
);

  localparam logic [3:0] StepMul  = 4'd0;
  localparam logic [3:0] StepLoad = 4'd1;
  localparam logic [3:0] StepEnd  = 4'(DivSteps + 1);

  logic              busy_q, done_q;
  logic [3:0]        step_q;
  logic [CoordW-1:0] p_q, dmag_q, den_q, rem_q, rem_d;
  logic              neg_q;
  logic [CoordW-2:0] a_q;
  logic [2*CoordW-2:0] prod_q;
  logic [QuoW-1:0]   quo_q, quo_d;

  logic [CoordW:0]   diff, dabs, den_full;
  logic [2*CoordW-1:0] dvd;
  logic [CoordW+1:0] pext, qext, sum;

  assign diff     = {q_i[CoordW-1], q_i} - {p_i[CoordW-1], p_i};
  assign dabs     = diff[CoordW] ? (~diff + 1'b1) : diff;
  assign den_full = {a_i[CoordW-1], a_i} - {b_i[CoordW-1], b_i};
  assign dvd      = {1'b0, prod_q} + {{(CoordW+1){1'b0}}, den_q[CoordW-1:1]};

  // three restoring steps per cycle
  always_comb begin
    logic [CoordW:0] t;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < BitsPerDv; k++) begin
      t     = {rem_d, quo_d[QuoW-1]};
      quo_d = {quo_d[QuoW-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t        = t - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= StepMul;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepMul;
    end else if (busy_q) begin
      if (step_q == StepEnd) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q    <= p_i;
      dmag_q <= dabs[CoordW-1:0];
      neg_q  <= diff[CoordW];
      a_q    <= a_i[CoordW-2:0];
      den_q  <= den_full[CoordW-1:0];
    end else if (busy_q) begin
      if (step_q == StepMul) begin
        prod_q <= (2*CoordW-1)'(dmag_q * a_q);
      end else if (step_q == StepLoad) begin
        rem_q <= {1'b0, dvd[2*CoordW-1:QuoW]};
        quo_q <= dvd[QuoW-1:0];
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
    end
  end

  assign pext  = {{2{p_q[CoordW-1]}}, p_q};
  assign qext  = {1'b0, quo_q};
  assign sum   = neg_q ? (pext - qext) : (pext + qext);
  assign res_o = sum[CoordW-1:0];
  assign done_o = done_q;

endmodule

// ===== src/tpc_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_emit
// merges kept vertices and lane split points into the output vertex stream
// ----------------------------------------------------------------------------
module tpc_emit
  import tpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  mode_e                    mode_i,
  input  vert_t                    k_i [3],
  input  vert_t                    s_i [NumSplit],
  output logic                     ready_o,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [CoordW-1:0] px_o,
  output logic signed [CoordW-1:0] py_o,
  output logic signed [CoordW-1:0] pz_o,
  output logic                     last_o
);

  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  mode_e           mode_q;
  vert_t           k_q [3];
  vert_t           s_q [NumSplit];
  vert_t           sel;
  logic            take;

  assign last_o  = emit_last(mode_q, idx_q);
  assign take    = busy_q && !stall_i;
  assign ready_o = !busy_q || (take && last_o);
  assign valid_o = busy_q;

  always_comb begin
    case (emit_src(mode_q, idx_q))
      SRC_K0:  sel = k_q[0];
      SRC_K1:  sel = k_q[1];
      SRC_S0:  sel = s_q[0];
      SRC_S1:  sel = s_q[1];
      default: sel = k_q[2];
    endcase
  end

  assign px_o = sel[0];
  assign py_o = sel[1];
  assign pz_o = sel[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      mode_q <= MODE_NONE;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      mode_q <= mode_i;
    end else if (take) begin
      if (last_o) busy_q <= 1'b0;
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      k_q <= k_i;
      s_q <= s_i;
    end
  end

endmodule

// ===== src/triangle_plane_clipper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// clips one triangle at the zero level of a per-vertex field, streams vertices
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o | three vertices x,y,z,val
//  out     | source    | out_valid_o / out_stall_i | px, py, pz, last
//
//  a request with an inside vertex holds the input while the six split lanes
//  run one multiply, one load, eleven radix-8 divide steps and a handoff;
//  the divider sets the rate, output stalls can stretch the handoff.
//  results then leave at one vertex per cycle unless out_stall_i is high
//  (3 or 9 per triangle), while the next request already runs in the lanes.
//  a request with no inside vertex is taken and produces nothing.
//  reset is asynchronous and clears only control state.
// ----------------------------------------------------------------------------
module triangle_plane_clipper
  import tpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] az_i,
  input  logic signed [CoordW-1:0] aval_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_i,
  input  logic signed [CoordW-1:0] bz_i,
  input  logic signed [CoordW-1:0] bval_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  input  logic signed [CoordW-1:0] cval_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] px_o,
  output logic signed [CoordW-1:0] py_o,
  output logic signed [CoordW-1:0] pz_o,
  output logic                     last_o
);

  // request decode
  vert_t             pos [3];
  logic [CoordW-1:0] val [3];
  logic [2:0]        is_in;
  logic [1:0]        num_in, cin, cout, i0, i1;
  logic [1:0]        pidx [NumSplit];
  logic [1:0]        qidx [NumSplit];
  mode_e             mode;
  vert_t             mid, kd [3];

  assign pos[0] = {az_i, ay_i, ax_i};
  assign pos[1] = {bz_i, by_i, bx_i};
  assign pos[2] = {cz_i, cy_i, cx_i};
  assign val[0] = aval_i;
  assign val[1] = bval_i;
  assign val[2] = cval_i;

  // inside means strictly above zero
  assign is_in[0] = (aval_i > 0);
  assign is_in[1] = (bval_i > 0);
  assign is_in[2] = (cval_i > 0);
  assign num_in = {1'b0, is_in[0]} + {1'b0, is_in[1]} + {1'b0, is_in[2]};
  assign cin    = is_in[2] ? 2'd2 : (is_in[1] ? 2'd1 : 2'd0);
  assign cout   = !is_in[2] ? 2'd2 : (!is_in[1] ? 2'd1 : 2'd0);
  assign i1     = nxt3(cout);
  assign i0     = nxt3(i1);

  // midpoint of the two inside vertices, floor of the exact sum
  always_comb begin
    logic [CoordW:0] s;
    for (int c = 0; c < NumCoord; c++) begin
      s = {pos[i0][c][CoordW-1], pos[i0][c]} + {pos[i1][c][CoordW-1], pos[i1][c]};
      mid[c] = s[CoordW:1];
    end
  end

  always_comb begin
    mode    = MODE_NONE;
    pidx[0] = i0;
    qidx[0] = cout;
    pidx[1] = i1;
    qidx[1] = cout;
    kd[0]   = pos[0];
    kd[1]   = pos[1];
    kd[2]   = pos[2];
    case (num_in)
      2'd1: begin
        mode    = MODE_ONE;
        pidx[0] = cin;
        qidx[0] = nxt3(cin);
        pidx[1] = cin;
        qidx[1] = nxt3(nxt3(cin));
        kd[2]   = pos[cin];
      end
      2'd2: begin
        mode  = MODE_TWO;
        kd[0] = pos[i0];
        kd[1] = pos[i1];
        kd[2] = mid;
      end
      2'd3: mode = MODE_ALL;
      default: mode = MODE_NONE;
    endcase
  end

  // compute slot: lanes plus the kept vertices of the request in flight
  logic  cbusy_q;
  mode_e cmode_q;
  vert_t ck_q [3];
  logic  in_take, start, xfer, emit_ready;
  logic  [NumLane-1:0] lane_done;
  vert_t split_res [NumSplit];

  assign in_stall_o = cbusy_q;
  assign in_take    = in_valid_i && !cbusy_q;
  assign start      = in_take && (mode != MODE_NONE);
  assign xfer       = cbusy_q && (&lane_done) && emit_ready;

  for (genvar s = 0; s < NumSplit; s++) begin : g_split
    for (genvar c = 0; c < NumCoord; c++) begin : g_coord
      tpc_split_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .start_i (start),
        .p_i     (pos[pidx[s]][c]),
        .q_i     (pos[qidx[s]][c]),
        .a_i     (val[pidx[s]]),
        .b_i     (val[qidx[s]]),
        .done_o  (lane_done[s*NumCoord+c]),
        .res_o   (split_res[s][c])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q <= 1'b0;
      cmode_q <= MODE_NONE;
    end else if (start) begin
      cbusy_q <= 1'b1;
      cmode_q <= mode;
    end else if (xfer) begin
      cbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) ck_q <= kd;
  end

  // merge stage and output sequencing
  tpc_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (xfer),
    .mode_i  (cmode_q),
    .k_i     (ck_q),
    .s_i     (split_res),
    .ready_o (emit_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .px_o    (px_o),
    .py_o    (py_o),
    .pz_o    (pz_o),
    .last_o  (last_o)
  );

`ifndef SYNTHESIS
  // lanes run in lockstep
  a_lane_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(lane_done) == 0) || ($countones(lane_done) == NumLane))
    else $error("split lanes out of step");

  // a new request clears every lane done flag
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (lane_done == '0) && cbusy_q)
    else $error("lanes not restarted");

  // handoff leaves the compute slot free
  a_xfer_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> !cbusy_q && out_valid_o)
    else $error("handoff did not complete");
`endif

endmodule
